// ===== hdl/dsca_pkg.sv =====
`default_nettype none
// ============================================================================
// dsca_pkg - shared types and constants for the clutch axis datapath
// Holds calibration defaults, fixed-point reciprocals, pipeline depths,
// the CSR index codes and the per-step record of the lane divider.
// ============================================================================
package dsca_pkg;

   // Field widths.
   localparam int SAMPLE_W = 12;
   localparam int GAIN_W   = 14;
   localparam int AXIS_W   = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 14;

   // Number of sample fields that each sensor carries in one word.
   localparam int SAMPLE_FIELDS = 3;

   // Full-scale mapped pedal value.
   localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'd4095;

   // Calibration defaults loaded at reset.
   localparam logic [SAMPLE_W-1:0] MASTER_LOW_RST  = 12'd1400;
   localparam logic [SAMPLE_W-1:0] MASTER_HIGH_RST = 12'd2950;
   localparam logic [SAMPLE_W-1:0] SLAVE_LOW_RST   = 12'd1500;
   localparam logic [SAMPLE_W-1:0] SLAVE_HIGH_RST  = 12'd2950;
   localparam logic [GAIN_W-1:0]   GAIN_RST        = 14'd4000;

   // Gain of 10000 hundredths of a percent is unity.
   localparam logic [GAIN_W-1:0] GAIN_UNITY = 14'd10000;

   // Exact floor division by 10000 for products below 2^26:
   // ceil(2^40 / 10000), taken over 40 fraction bits.
   localparam logic [26:0] GAIN_RECIP = 27'd109951163;
   localparam int          GAIN_SHIFT = 40;

   // Axis scaling: v * 65474 / 4095 by ceil(2^42 / 4095) over 42 bits.
   localparam logic [16:0] AXIS_SPAN  = 17'd65474;
   localparam logic [30:0] AXIS_RECIP = 31'd1074004033;
   localparam int          AXIS_SHIFT = 42;
   localparam logic [AXIS_W:0] AXIS_TOP = 17'd32737;

   // Averaging reciprocal fraction bits.
   localparam int AVG_SHIFT = 16;

   // Divider: one saturation step plus one step per quotient bit.
   localparam int DIV_STEPS = SAMPLE_W + 1;
   localparam int REM_W     = 2 * SAMPLE_W;

   // Pipeline depths of the lane and of the merge stage.
   localparam int LANE_LATENCY  = 3 + DIV_STEPS + 1;
   localparam int MERGE_LATENCY = 5;

   // CSR index codes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MASTER_LOW  = 3'd0,
      CSR_MASTER_HIGH = 3'd1,
      CSR_SLAVE_LOW   = 3'd2,
      CSR_SLAVE_HIGH  = 3'd3,
      CSR_SLAVE_GAIN  = 3'd4
   } csr_index_type;

   // One step of the pipelined span divider.
   typedef struct packed {
      logic [REM_W-1:0]    rem;
      logic [SAMPLE_W-1:0] divisor;
      logic [SAMPLE_W-1:0] quo;
      logic                sat;
      logic                flat;
      logic                above;
      logic                neg;
   } div_stage_type;

endpackage
`default_nettype wire

// ===== hdl/dsca_lane.sv =====
`default_nettype none
// ============================================================================
// dsca_lane - one sensor lane: average, inverse span map, clamp
// Sums the samples, divides by the count with a reciprocal, then maps the
// average onto 4095..0 through a 13-step pipelined restoring divider.
// ============================================================================
module dsca_lane #(
   parameter int SAMPLES_PER_SENSOR = 3
) (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire logic [dsca_pkg::SAMPLE_W-1:0] samp_a,
   input  wire logic [dsca_pkg::SAMPLE_W-1:0] samp_b,
   input  wire logic [dsca_pkg::SAMPLE_W-1:0] samp_c,
   input  wire logic [dsca_pkg::SAMPLE_W-1:0] span_low,
   input  wire logic [dsca_pkg::SAMPLE_W-1:0] span_high,
   output logic      [dsca_pkg::SAMPLE_W-1:0] mapped
);

   localparam int SampleCount = (SAMPLES_PER_SENSOR > dsca_pkg::SAMPLE_FIELDS) ?
                                dsca_pkg::SAMPLE_FIELDS :
                                ((SAMPLES_PER_SENSOR < 1) ? 1 : SAMPLES_PER_SENSOR);
   localparam int SumW = dsca_pkg::SAMPLE_W + 2;
   localparam int RecipW = dsca_pkg::AVG_SHIFT + 1;
   localparam logic [RecipW-1:0] AvgRecip =
      RecipW'(((2 ** dsca_pkg::AVG_SHIFT) + SampleCount - 1) / SampleCount);
   localparam int Sw = dsca_pkg::SAMPLE_W;

   logic [SumW-1:0]        sum_ff, sum_in;
   logic [Sw-1:0]          avg_ff, avg_in;
   logic [SumW+RecipW-1:0] avg_prod;
   dsca_pkg::div_stage_type prep_ff, prep_in;
   dsca_pkg::div_stage_type div_src [dsca_pkg::DIV_STEPS];
   dsca_pkg::div_stage_type div_ff  [dsca_pkg::DIV_STEPS];
   dsca_pkg::div_stage_type div_in  [dsca_pkg::DIV_STEPS];
   dsca_pkg::div_stage_type last;
   logic [Sw-1:0]          map_ff, map_in;
   logic [Sw-1:0]          adiff;
   logic                   above, below, d_up, d_dn;

   // Sum the samples that take part in the average.
   always_comb begin
      sum_in = SumW'(samp_a);
      if (SampleCount >= 2) begin
         sum_in = sum_in + SumW'(samp_b);
      end
      if (SampleCount >= 3) begin
         sum_in = sum_in + SumW'(samp_c);
      end
   end

   // Truncating average through a reciprocal that is exact over the sum range.
   always_comb begin
      avg_prod = (SumW + RecipW)'(sum_ff) * (SumW + RecipW)'(AvgRecip);
      avg_in   = avg_prod[dsca_pkg::AVG_SHIFT +: Sw];
   end

   // Set up the magnitudes and the sign of the span quotient.
   always_comb begin
      above = avg_ff > span_low;
      below = avg_ff < span_low;
      d_up  = span_high > span_low;
      d_dn  = span_high < span_low;
      adiff = above ? (avg_ff - span_low) : (span_low - avg_ff);
      prep_in.rem     = {adiff, {Sw{1'b0}}} - dsca_pkg::REM_W'(adiff);
      prep_in.divisor = d_up ? (span_high - span_low) : (span_low - span_high);
      prep_in.quo     = '0;
      prep_in.sat     = 1'b0;
      prep_in.flat    = (span_high == span_low);
      prep_in.above   = above;
      prep_in.neg     = (above && d_up) || (below && d_dn);
   end

   // Front registers of the lane.
   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff  <= sum_in;
         avg_ff  <= avg_in;
         prep_ff <= prep_in;
      end
   end

   // Divider pipeline: the first step flags a quotient of 4096 or more,
   // every later step settles one quotient bit.
   assign div_src[0] = prep_ff;

   for (genvar j = 0; j < dsca_pkg::DIV_STEPS; j++) begin : g_div
      logic [dsca_pkg::REM_W-1:0] step_sub;
      logic                       fits;

      if (j > 0) begin : g_link
         assign div_src[j] = div_ff[j-1];
      end

      assign step_sub = dsca_pkg::REM_W'(div_src[j].divisor) << (dsca_pkg::DIV_STEPS - 1 - j);
      assign fits     = div_src[j].rem >= step_sub;

      if (j == 0) begin : g_sat
         always_comb begin
            div_in[j]     = div_src[j];
            div_in[j].sat = fits;
         end
      end else begin : g_bit
         always_comb begin
            div_in[j] = div_src[j];
            if (fits) begin
               div_in[j].rem = div_src[j].rem - step_sub;
               div_in[j].quo[dsca_pkg::DIV_STEPS - 1 - j] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            div_ff[j] <= div_in[j];
         end
      end
   end

   // Final map with clamp to 0..4095.
   assign last = div_ff[dsca_pkg::DIV_STEPS-1];

   always_comb begin
      if (last.flat) begin
         map_in = last.above ? '0 : dsca_pkg::FULL_SCALE;
      end else if (last.neg) begin
         map_in = last.sat ? '0 : (dsca_pkg::FULL_SCALE - last.quo);
      end else begin
         map_in = dsca_pkg::FULL_SCALE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         map_ff <= map_in;
      end
   end

   assign mapped = map_ff;

endmodule
`default_nettype wire

// ===== hdl/dsca_merge.sv =====
`default_nettype none
// ============================================================================
// dsca_merge - combines the two lane results into the axis value
// Scales the slave value by the gain, takes the larger value and maps it
// onto 32737..-32737, with at most one multiplier per stage.
// ============================================================================
module dsca_merge (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire logic [dsca_pkg::SAMPLE_W-1:0] master_val,
   input  wire logic [dsca_pkg::SAMPLE_W-1:0] slave_val,
   input  wire logic [dsca_pkg::GAIN_W-1:0]   gain,
   output logic      [dsca_pkg::AXIS_W-1:0]   axis
);

   localparam int Sw = dsca_pkg::SAMPLE_W;
   localparam int P1W = Sw + dsca_pkg::GAIN_W;
   localparam int P2W = P1W + 27;
   localparam int P4W = 28;
   localparam int P5W = P4W + 31;

   logic [dsca_pkg::GAIN_W-1:0] gain_sat;
   logic [P1W-1:0]              p1_ff, p1_in;
   logic [P2W-1:0]              p2_ff, p2_in;
   logic [Sw-1:0]               m1_ff, m2_ff;
   logic [Sw-1:0]               scaled;
   logic [Sw-1:0]               v3_ff, v3_in;
   logic [P4W-1:0]              p4_ff;
   logic [P4W:0]                p4_full;
   logic [P5W-1:0]              p5_ff, p5_in;
   logic [dsca_pkg::AXIS_W-1:0] quot;
   logic [dsca_pkg::AXIS_W:0]   axis_wide;

   // Gain above unity saturates; slave value times gain.
   always_comb begin
      gain_sat = (gain > dsca_pkg::GAIN_UNITY) ? dsca_pkg::GAIN_UNITY : gain;
      p1_in    = P1W'(slave_val) * P1W'(gain_sat);
   end

   // Divide the scaled product by 10000 with the reciprocal.
   assign p2_in = P2W'(p1_ff) * P2W'(dsca_pkg::GAIN_RECIP);

   // Larger of master and scaled slave.
   always_comb begin
      scaled = p2_ff[dsca_pkg::GAIN_SHIFT +: Sw];
      v3_in  = (scaled > m2_ff) ? scaled : m2_ff;
   end

   // Axis scaling: v * 65474, then divide by 4095 with the reciprocal.
   assign p4_full = (P4W + 1)'(v3_ff) * (P4W + 1)'(dsca_pkg::AXIS_SPAN);
   assign p5_in   = P5W'(p4_ff) * P5W'(dsca_pkg::AXIS_RECIP);

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff <= p1_in;
         m1_ff <= master_val;
         p2_ff <= p2_in;
         m2_ff <= m1_ff;
         v3_ff <= v3_in;
         p4_ff <= p4_full[P4W-1:0];
         p5_ff <= p5_in;
      end
   end

   // Offset so that zero travel reads 32737 and full travel -32737.
   always_comb begin
      quot      = p5_ff[dsca_pkg::AXIS_SHIFT +: dsca_pkg::AXIS_W];
      axis_wide = dsca_pkg::AXIS_TOP - {1'b0, quot};
      axis      = axis_wide[dsca_pkg::AXIS_W-1:0];
   end

endmodule
`default_nettype wire

// ===== hdl/dual_sensor_clutch_axis.sv =====
`default_nettype none
// Throughput: one word per cycle while the skid register is empty; the
// 13-stage compare-subtract divider in each lane and the multiplier stages of
// the merge are fully pipelined. A stalled result is held in the output
// register plus one skid register. Reset clears all valid flags and loads
// the calibration defaults.
// ============================================================================
// dual_sensor_clutch_axis - clutch pedal axis from master and slave sensors
// Two lanes average and span-map each sensor side by side; the merge stage
// applies the slave gain, picks the larger value and forms the axis word.
// ============================================================================
module dual_sensor_clutch_axis #(
   parameter int SAMPLES_PER_SENSOR = 3
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [dsca_pkg::SAMPLE_W-1:0]  req_master_sample_a,
   input  wire logic [dsca_pkg::SAMPLE_W-1:0]  req_master_sample_b,
   input  wire logic [dsca_pkg::SAMPLE_W-1:0]  req_master_sample_c,
   input  wire logic [dsca_pkg::SAMPLE_W-1:0]  req_slave_sample_a,
   input  wire logic [dsca_pkg::SAMPLE_W-1:0]  req_slave_sample_b,
   input  wire logic [dsca_pkg::SAMPLE_W-1:0]  req_slave_sample_c,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic signed [dsca_pkg::AXIS_W-1:0]  rsp_axis_value,
   input  wire logic                           csr_we,
   input  wire logic [dsca_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [dsca_pkg::CSR_DAT_W-1:0] csr_wdata
);

   localparam int TotalLat = dsca_pkg::LANE_LATENCY + dsca_pkg::MERGE_LATENCY;
   localparam int Sw = dsca_pkg::SAMPLE_W;

   logic [Sw-1:0]               master_low_ff, master_high_ff;
   logic [Sw-1:0]               slave_low_ff, slave_high_ff;
   logic [dsca_pkg::GAIN_W-1:0] gain_ff;
   logic                        en;
   logic [TotalLat-1:0]         vld_ff, vld_in;
   logic [Sw-1:0]               master_val, slave_val;
   logic [dsca_pkg::AXIS_W-1:0] axis;
   logic                        arrive;
   logic                        rsp_vld_ff, rsp_vld_in;
   logic [dsca_pkg::AXIS_W-1:0] rsp_axis_ff, rsp_axis_in;
   logic                        skid_vld_ff, skid_vld_in;
   logic [dsca_pkg::AXIS_W-1:0] skid_axis_ff, skid_axis_in;

   // Calibration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         master_low_ff  <= dsca_pkg::MASTER_LOW_RST;
         master_high_ff <= dsca_pkg::MASTER_HIGH_RST;
         slave_low_ff   <= dsca_pkg::SLAVE_LOW_RST;
         slave_high_ff  <= dsca_pkg::SLAVE_HIGH_RST;
         gain_ff        <= dsca_pkg::GAIN_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            dsca_pkg::CSR_MASTER_LOW:  master_low_ff  <= csr_wdata[Sw-1:0];
            dsca_pkg::CSR_MASTER_HIGH: master_high_ff <= csr_wdata[Sw-1:0];
            dsca_pkg::CSR_SLAVE_LOW:   slave_low_ff   <= csr_wdata[Sw-1:0];
            dsca_pkg::CSR_SLAVE_HIGH:  slave_high_ff  <= csr_wdata[Sw-1:0];
            dsca_pkg::CSR_SLAVE_GAIN:  gain_ff        <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The whole pipeline advances unless the skid register is occupied.
   assign en        = !skid_vld_ff;
   assign req_ready = en;

   // Valid flags travel alongside the lane and merge data.
   assign vld_in = {vld_ff[TotalLat-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   dsca_lane #(
      .SAMPLES_PER_SENSOR (SAMPLES_PER_SENSOR)
   ) u_master_lane (
      .clock     (clock),
      .en        (en),
      .samp_a    (req_master_sample_a),
      .samp_b    (req_master_sample_b),
      .samp_c    (req_master_sample_c),
      .span_low  (master_low_ff),
      .span_high (master_high_ff),
      .mapped    (master_val)
   );

   dsca_lane #(
      .SAMPLES_PER_SENSOR (SAMPLES_PER_SENSOR)
   ) u_slave_lane (
      .clock     (clock),
      .en        (en),
      .samp_a    (req_slave_sample_a),
      .samp_b    (req_slave_sample_b),
      .samp_c    (req_slave_sample_c),
      .span_low  (slave_low_ff),
      .span_high (slave_high_ff),
      .mapped    (slave_val)
   );

   dsca_merge u_merge (
      .clock      (clock),
      .en         (en),
      .master_val (master_val),
      .slave_val  (slave_val),
      .gain       (gain_ff),
      .axis       (axis)
   );

   // Output register with a skid register behind it.
   assign arrive = en && vld_ff[TotalLat-1];

   always_comb begin
      rsp_vld_in   = rsp_vld_ff;
      rsp_axis_in  = rsp_axis_ff;
      skid_vld_in  = skid_vld_ff;
      skid_axis_in = skid_axis_ff;
      if (!rsp_vld_ff || rsp_ready) begin
         if (skid_vld_ff) begin
            rsp_vld_in  = 1'b1;
            rsp_axis_in = skid_axis_ff;
            skid_vld_in = 1'b0;
         end else begin
            rsp_vld_in  = arrive;
            rsp_axis_in = axis;
         end
      end else if (arrive) begin
         skid_vld_in  = 1'b1;
         skid_axis_in = axis;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff  <= rsp_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_axis_ff  <= rsp_axis_in;
      skid_axis_ff <= skid_axis_in;
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_axis_value = rsp_axis_ff;

   // The skid register only holds a word behind a waiting output word.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> rsp_vld_ff)
      else $error("skid word held without an output word");

   // The skid register fills only when the output word was stalled.
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_vld_ff) |-> $past(rsp_vld_ff && !rsp_ready))
      else $error("skid filled while the output was free");

   // A taken output word is replaced by the skid word at once.
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_ready && skid_vld_ff) |=> (rsp_vld_ff && !skid_vld_ff))
      else $error("skid word not moved to the output");

   // Every delivered axis word stays within the gamepad range.
   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (($signed(rsp_axis_ff) >= -16'sd32737) &&
                      ($signed(rsp_axis_ff) <= 16'sd32737)))
      else $error("axis word out of range");

endmodule
`default_nettype wire
